// File: src/wsdw_pkg.sv
// ----------------------------------------------------------------------------
// Word-serial divider package
// Shared constants and the command/status types that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package wsdw_pkg;

   // Width of every payload field on the channels
   localparam int IO_BITS = 64;

   // Default word width of the arithmetic
   localparam int WORD_BITS_DEF = 64;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept_pre;   // take a word, set up reduction of the kept remainder
      logic accept_main;  // take a word, set up the main division directly
      logic step;         // one restoring shift/subtract step
      logic to_main;      // last reduction step, then reload for the main pass
      logic finish;       // load the result register, update kept remainder
   } wsdw_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic need_pre;     // kept remainder is not below the divisor
   } wsdw_status_type;

endpackage

// File: src/wsdw_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one dividend word and its final-word mark per transfer.
// ----------------------------------------------------------------------------
interface wsdw_req_if import wsdw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [IO_BITS-1:0] dividend_word;
   logic               final_word;

   modport source (output valid, output dividend_word, output final_word, input ready);
   modport sink   (input valid, input dividend_word, input final_word, output ready);
endinterface

// File: src/wsdw_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries one quotient word, the running remainder and the last mark.
// ----------------------------------------------------------------------------
interface wsdw_rsp_if import wsdw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [IO_BITS-1:0] quotient_word;
   logic [IO_BITS-1:0] remainder_word;
   logic               is_last;

   modport source (output valid, output quotient_word, output remainder_word,
                   output is_last, input ready);
   modport sink   (input valid, input quotient_word, input remainder_word,
                   input is_last, output ready);
endinterface

// File: src/wsdw_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the divisor register write data.
// ----------------------------------------------------------------------------
interface wsdw_csr_if import wsdw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [IO_BITS-1:0] divisor;

   modport source (output valid, output divisor, input ready);
   modport sink   (input valid, input divisor, output ready);
endinterface

// File: src/wsdw_dpath.sv
// ----------------------------------------------------------------------------
// Word-serial divider datapath
// Divisor and kept remainder registers, a radix-2 restoring divide unit
// and the result register.
// ----------------------------------------------------------------------------
module wsdw_dpath import wsdw_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  wsdw_cmd_type       cmd,
   output wsdw_status_type    status,
   input  logic [IO_BITS-1:0] req_word,
   input  logic               req_final,
   input  logic               csr_write,
   input  logic [IO_BITS-1:0] csr_data,
   output logic [IO_BITS-1:0] rsp_quotient,
   output logic [IO_BITS-1:0] rsp_remainder,
   output logic               rsp_last
);

   logic [WORD_BITS-1:0] div_ff, div_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in;
   logic [WORD_BITS-1:0] p_ff, p_in;
   logic [WORD_BITS-1:0] lo_ff, lo_in;
   logic [WORD_BITS-1:0] q_ff, q_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic                 last_ff, last_in;
   logic [WORD_BITS-1:0] quo_out_ff, quo_out_in;
   logic [WORD_BITS-1:0] rem_out_ff, rem_out_in;
   logic                 last_out_ff, last_out_in;

   logic [WORD_BITS-1:0] csr_value;
   logic [WORD_BITS-1:0] shifted;
   logic                 sub;
   logic [WORD_BITS-1:0] p_step;

   assign csr_value = csr_data[WORD_BITS-1:0];

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {p_ff[WORD_BITS-2:0], lo_ff[WORD_BITS-1]};
      sub     = p_ff[WORD_BITS-1] | (shifted >= div_ff);
      p_step  = sub ? (shifted - div_ff) : shifted;
   end

   assign status.need_pre = (rem_ff >= div_ff);

   // Next values of the working and result registers
   always_comb begin
      div_in      = div_ff;
      rem_in      = rem_ff;
      p_in        = p_ff;
      lo_in       = lo_ff;
      q_in        = q_ff;
      word_in     = word_ff;
      last_in     = last_ff;
      quo_out_in  = quo_out_ff;
      rem_out_in  = rem_out_ff;
      last_out_in = last_out_ff;

      // drop zero divisor writes
      if (csr_write && (csr_value != '0)) begin
         div_in = csr_value;
      end

      if (cmd.accept_pre) begin
         // reduce the kept remainder first: divide (0 : remainder)
         p_in    = '0;
         lo_in   = rem_ff;
         word_in = req_word[WORD_BITS-1:0];
         last_in = req_final;
      end
      if (cmd.accept_main) begin
         p_in    = rem_ff;
         lo_in   = req_word[WORD_BITS-1:0];
         word_in = req_word[WORD_BITS-1:0];
         last_in = req_final;
      end
      if (cmd.step) begin
         p_in  = p_step;
         lo_in = {lo_ff[WORD_BITS-2:0], 1'b0};
         q_in  = {q_ff[WORD_BITS-2:0], sub};
      end
      if (cmd.to_main) begin
         // reduced remainder becomes the high half of the main division
         p_in  = p_step;
         lo_in = word_ff;
      end
      if (cmd.finish) begin
         quo_out_in  = q_ff;
         rem_out_in  = p_ff;
         last_out_in = last_ff;
         rem_in      = last_ff ? '0 : p_ff;
      end
   end

   // Control-relevant state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= WORD_BITS'(1);
         rem_ff <= '0;
      end else begin
         div_ff <= div_in;
         rem_ff <= rem_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      lo_ff       <= lo_in;
      q_ff        <= q_in;
      word_ff     <= word_in;
      last_ff     <= last_in;
      quo_out_ff  <= quo_out_in;
      rem_out_ff  <= rem_out_in;
      last_out_ff <= last_out_in;
   end

   assign rsp_quotient  = IO_BITS'(quo_out_ff);
   assign rsp_remainder = IO_BITS'(rem_out_ff);
   assign rsp_last      = last_out_ff;

endmodule

// File: src/wsdw_ctrl.sv
// ----------------------------------------------------------------------------
// Word-serial divider controller
// Sequences the optional remainder reduction pass, the main division pass
// and the hand-off into the result register.
// ----------------------------------------------------------------------------
module wsdw_ctrl import wsdw_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  wsdw_status_type status,
   output wsdw_cmd_type    cmd
);

   localparam int CNT_BITS = $clog2(WORD_BITS);
   localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(WORD_BITS - 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PRE  = 4'b0010,
      S_MAIN = 4'b0100,
      S_DONE = 4'b1000
   } wsdw_state_type;

   wsdw_state_type      state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state, step counter and datapath commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (status.need_pre) begin
                  cmd.accept_pre = 1'b1;
                  state_in       = S_PRE;
               end else begin
                  cmd.accept_main = 1'b1;
                  state_in        = S_MAIN;
               end
            end
         end
         S_PRE: begin
            if (cnt_ff == LAST_CNT) begin
               cmd.to_main = 1'b1;
               cnt_in      = '0;
               state_in    = S_MAIN;
            end else begin
               cmd.step = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         S_MAIN: begin
            cmd.step = 1'b1;
            if (cnt_ff == LAST_CNT) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   // Result register valid: set on finish, clear on transfer
   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted word always starts a division pass
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_PRE || state_ff == S_MAIN))
      else $error("accepted word did not start a division pass");

   // The step counter runs only inside a division pass
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (state_ff == S_PRE || state_ff == S_MAIN))
      else $error("step counter running outside a division pass");

   // A finished result never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // A result becomes valid only in the cycle after a finish
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("result valid without a finished division");

endmodule

// File: src/word_serial_divide_by_word.sv
// Sequence: a request transfer starts the main pass, or first a reduction
//   pass when the kept remainder must be reduced (divisor changed in the
//   middle of a dividend); then the result register is loaded once free.
// Flow: a new word is taken only when idle, after the last one is finished;
//   the radix-2 divide unit does one shift/subtract step per cycle.
// Reset: divisor = 1, kept remainder = 0, no result pending.
// ----------------------------------------------------------------------------
// Word-serial divide by word
// Divides a long unsigned integer, streamed most significant word first,
// by a single-word divisor; returns quotient words and the running remainder.
// ----------------------------------------------------------------------------
module word_serial_divide_by_word import wsdw_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   wsdw_req_if.sink      req_chan,
   wsdw_rsp_if.source    rsp_chan,
   wsdw_csr_if.sink      csr_chan
);

   wsdw_cmd_type    cmd;
   wsdw_status_type status;
   logic            csr_write;

   // Divisor channel takes a write every cycle; zero writes are dropped
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid & csr_chan.ready;

   wsdw_ctrl #(
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wsdw_dpath #(
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_word      (req_chan.dividend_word),
      .req_final     (req_chan.final_word),
      .csr_write     (csr_write),
      .csr_data      (csr_chan.divisor),
      .rsp_quotient  (rsp_chan.quotient_word),
      .rsp_remainder (rsp_chan.remainder_word),
      .rsp_last      (rsp_chan.is_last)
   );

endmodule
